// ===== rtl/uep_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// uep_seq_pkg
// Shared types, register indexes and reset values of the ranging sequencer.
// ----------------------------------------------------------------------------
package uep_seq_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_TRIG_LOW   = 3'd0;
	localparam logic [2:0] REG_TRIG_HIGH  = 3'd1;
	localparam logic [2:0] REG_TIMEOUT    = 3'd2;
	localparam logic [2:0] REG_COUNT_CAP  = 3'd3;
	localparam logic [2:0] REG_NEAR_LOW   = 3'd4;
	localparam logic [2:0] REG_NEAR_HIGH  = 3'd5;
	localparam logic [2:0] REG_PAUSE      = 3'd6;

	// Reset values of the registers
	localparam logic [15:0] RST_TRIG_LOW  = 16'd40;
	localparam logic [15:0] RST_TRIG_HIGH = 16'd400;
	localparam logic [19:0] RST_TIMEOUT   = 20'd500000;
	localparam logic [19:0] RST_COUNT_CAP = 20'd100000;
	localparam logic [19:0] RST_NEAR_LOW  = 20'd10;
	localparam logic [19:0] RST_NEAR_HIGH = 20'd5000;
	localparam logic [23:0] RST_PAUSE     = 24'd4000000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [4:0] {
		PH_TRIG_LOW  = 5'b00001,
		PH_TRIG_HIGH = 5'b00010,
		PH_WAIT      = 5'b00100,
		PH_MEASURE   = 5'b01000,
		PH_PAUSE     = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [19:0] echo_count;
		logic        measure_done;
		logic        near_flag;
		logic        trigger_level;
	} result_t;

endpackage

// ===== rtl/ultrasonic_echo_proximity_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_proximity_sequencer_core
// Tick-driven ultrasonic ranging sequencer with held proximity flag.
// ----------------------------------------------------------------------------
// Output: each accepted input transaction has its result in the output
//   register from the next cycle on.
// Throughput: one transaction per cycle; s_axis_tready drops only while a
//   result waits in the output register and the sink does not take it.
// Reset: arst_n clears phase to trigger low, all counters, the held flag and
//   count, and loads the registers with their documented defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_proximity_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: tdata[0] echo_level, tdata[7:1] zero
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	// master stream: tdata[0] trigger_level, [1] near_flag, [2] measure_done,
	// [22:3] echo_count, [23] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// Configuration registers
	logic [15:0] trig_low_q;
	logic [15:0] trig_high_q;
	logic [19:0] timeout_q;
	logic [19:0] count_cap_q;
	logic [19:0] near_low_q;
	logic [19:0] near_high_q;
	logic [23:0] pause_q;

	// Sequencer state
	uep_seq_pkg::phase_t phase_q, phase_d;
	logic [23:0] phase_ticks_q, phase_ticks_d;
	logic [19:0] high_count_q, high_count_d;
	logic        near_q, near_d;
	logic [19:0] last_count_q, last_count_d;

	// Output register
	logic                  out_valid_q;
	uep_seq_pkg::result_t  out_q;

	logic        in_fire;
	logic        echo;
	logic        trig;
	logic        done;
	logic [23:0] ticks_inc;
	logic [23:0] timed_len;
	logic        timed_end;
	logic [19:0] fin_count;
	logic        finish;

	// Writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_low_q  <= uep_seq_pkg::RST_TRIG_LOW;
			trig_high_q <= uep_seq_pkg::RST_TRIG_HIGH;
			timeout_q   <= uep_seq_pkg::RST_TIMEOUT;
			count_cap_q <= uep_seq_pkg::RST_COUNT_CAP;
			near_low_q  <= uep_seq_pkg::RST_NEAR_LOW;
			near_high_q <= uep_seq_pkg::RST_NEAR_HIGH;
			pause_q     <= uep_seq_pkg::RST_PAUSE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uep_seq_pkg::REG_TRIG_LOW:  trig_low_q  <= cfg_data[15:0];
				uep_seq_pkg::REG_TRIG_HIGH: trig_high_q <= cfg_data[15:0];
				uep_seq_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data[19:0];
				uep_seq_pkg::REG_COUNT_CAP: count_cap_q <= cfg_data[19:0];
				uep_seq_pkg::REG_NEAR_LOW:  near_low_q  <= cfg_data[19:0];
				uep_seq_pkg::REG_NEAR_HIGH: near_high_q <= cfg_data[19:0];
				uep_seq_pkg::REG_PAUSE:     pause_q     <= cfg_data;
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	// Take a new tick whenever the output register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign echo          = s_axis_tdata[0];

	// Shared tick counter for the timed phases; wraps at 24 bits
	assign ticks_inc = phase_ticks_q + 24'd1;

	always_comb begin
		case (phase_q)
			uep_seq_pkg::PH_TRIG_HIGH: timed_len = {8'd0, trig_high_q};
			uep_seq_pkg::PH_PAUSE:     timed_len = pause_q;
			default:                   timed_len = {8'd0, trig_low_q};
		endcase
	end

	always_comb begin
		phase_d       = phase_q;
		phase_ticks_d = phase_ticks_q;
		high_count_d  = high_count_q;
		trig          = 1'b0;
		done          = 1'b0;
		finish        = 1'b0;
		fin_count     = 20'd0;
		timed_end     = 1'b0;
		case (phase_q)
			uep_seq_pkg::PH_TRIG_HIGH: begin
				trig      = 1'b1;
				timed_end = ticks_inc >= timed_len;
				phase_ticks_d = timed_end ? 24'd0 : ticks_inc;
				if (timed_end) begin
					phase_d = uep_seq_pkg::PH_WAIT;
				end
			end
			uep_seq_pkg::PH_WAIT: begin
				// Timeout is checked before the echo is looked at
				if (phase_ticks_q >= {4'd0, timeout_q}) begin
					finish    = 1'b1;
					fin_count = 20'd0;
				end else if (echo) begin
					phase_d       = uep_seq_pkg::PH_MEASURE;
					phase_ticks_d = 24'd0;
					high_count_d  = 20'd0;
				end else begin
					phase_ticks_d = ticks_inc;
				end
			end
			uep_seq_pkg::PH_MEASURE: begin
				if (echo && (high_count_q < count_cap_q)) begin
					high_count_d = high_count_q + 20'd1;
				end else begin
					finish    = 1'b1;
					fin_count = high_count_q;
				end
			end
			uep_seq_pkg::PH_PAUSE: begin
				timed_end = ticks_inc >= timed_len;
				phase_ticks_d = timed_end ? 24'd0 : ticks_inc;
				if (timed_end) begin
					phase_d = uep_seq_pkg::PH_TRIG_LOW;
				end
			end
			uep_seq_pkg::PH_TRIG_LOW: begin
				timed_end = ticks_inc >= timed_len;
				phase_ticks_d = timed_end ? 24'd0 : ticks_inc;
				if (timed_end) begin
					phase_d = uep_seq_pkg::PH_TRIG_HIGH;
				end
			end
			default: begin
				// Unknown code restarts the trigger low phase from zero
				phase_d       = uep_seq_pkg::PH_TRIG_LOW;
				phase_ticks_d = 24'd1;
				timed_end     = 24'd1 >= timed_len;
				if (timed_end) begin
					phase_d       = uep_seq_pkg::PH_TRIG_HIGH;
					phase_ticks_d = 24'd0;
				end
			end
		endcase

		// Measurement end: latch count, evaluate window, go to pause
		last_count_d = last_count_q;
		near_d       = near_q;
		if (finish) begin
			done          = 1'b1;
			last_count_d  = fin_count;
			near_d        = (fin_count > near_low_q) && (fin_count < near_high_q);
			phase_d       = uep_seq_pkg::PH_PAUSE;
			phase_ticks_d = 24'd0;
			high_count_d  = 20'd0;
		end
	end

	// Advance the sequencer on every accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= uep_seq_pkg::PH_TRIG_LOW;
			phase_ticks_q <= 24'd0;
			high_count_q  <= 20'd0;
			near_q        <= 1'b0;
			last_count_q  <= 20'd0;
		end else if (in_fire) begin
			phase_q       <= phase_d;
			phase_ticks_q <= phase_ticks_d;
			high_count_q  <= high_count_d;
			near_q        <= near_d;
			last_count_q  <= last_count_d;
		end
	end

	// Output register: hold the result until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q.trigger_level <= trig;
			out_q.near_flag     <= near_d;
			out_q.measure_done  <= done;
			out_q.echo_count    <= last_count_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

`ifndef SYNTHESIS
	// A finished measurement never shares its tick with a trigger pulse
	a_done_no_trig: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[0]))
		else $error("measure_done together with trigger_level");

	// Input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output register");

	// Every accepted tick leaves a result behind
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> m_axis_tvalid)
		else $error("accepted tick produced no result");

	// A low-echo poll in the wait phase advances the poll counter by one
	a_wait_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == uep_seq_pkg::PH_WAIT && phase_d == uep_seq_pkg::PH_WAIT)
		|=> phase_ticks_q == $past(phase_ticks_q) + 24'd1)
		else $error("wait phase poll count did not advance");
`endif

endmodule
